FILE: rtl/sdvd_pkg.sv
// ----------------------------------------------------------------------------
// sdvd_pkg
// Shared types and widths of the sphere dent vertex deformer.
// ----------------------------------------------------------------------------
package sdvd_pkg;

  // Coordinate width: signed fixed point, fraction bits do not enter the maths.
  localparam int CW = 16;
  // Magnitude width of an inside offset and of the distance root.
  localparam int LW = CW - 1;
  // Width of a squared distance of an inside vertex.
  localparam int TW = 2 * LW;
  // Width of the rounded division numerator.
  localparam int NW = TW + 1;
  // Quotient width: an applied offset never exceeds the radius.
  localparam int QW = CW;
  // Cells of the root and division chains.
  localparam int SQRT_CELLS = LW;
  localparam int DIV_CELLS  = QW;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CW-1:0] src_x;
    logic [CW-1:0] src_y;
    logic [CW-1:0] src_z;
    logic [CW-1:0] ref_x;
    logic [CW-1:0] ref_y;
    logic [CW-1:0] ref_z;
    logic          last_vertex;
  } in_t;

  typedef struct packed {
    logic [CW-1:0] out_x;
    logic [CW-1:0] out_y;
    logic [CW-1:0] out_z;
    logic          was_inside;
    logic          last_result;
  } out_t;

  typedef struct packed {
    logic [2:0][CW-1:0] cen;
    logic [LW-1:0]      rad;
    logic [TW-1:0]      rsq;
  } cfg_t;

  // Per-vertex context that travels down the whole chain.
  typedef struct packed {
    logic [2:0][CW-1:0] src;
    logic [2:0][CW-1:0] lim;
    logic [2:0]         neg;
    logic [2:0][LW-1:0] mag;
    logic               in_sphere;
    logic               last;
  } ctx_t;

  typedef struct packed {
    ctx_t          ctx;
    logic [LW:0]   rem;
    logic [LW-1:0] root;
    logic [TW-1:0] rad;
  } sq_t;

  typedef struct packed {
    ctx_t               ctx;
    logic [LW-1:0]      len;
    logic [2:0][LW-1:0] rem;
    logic [2:0][QW-1:0] feed;
    logic [2:0][QW-1:0] quo;
  } dv_t;

endpackage

FILE: rtl/sdvd_front.sv
// ----------------------------------------------------------------------------
// sdvd_front
// Offsets from the centre, squares and the inside test, three stages.
// ----------------------------------------------------------------------------
module sdvd_front import sdvd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output sq_t  out_data
);

  logic [2:0]         v_r;
  logic [2:0]         rdy;
  ctx_t               c1_r, c1_nxt;
  ctx_t               c2_r;
  logic [2:0][TW-1:0] sq_r, sq_nxt;
  sq_t                o_r, o_nxt;

  assign rdy[2]    = !v_r[2] || out_ready;
  assign rdy[1]    = !v_r[1] || rdy[2];
  assign rdy[0]    = !v_r[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v_r[2];
  assign out_data  = o_r;

  always_comb begin
    logic signed [CW:0] d;
    logic [CW:0]        a;
    logic [2:0][CW-1:0] s;
    c1_nxt.src  = {in_data.src_z, in_data.src_y, in_data.src_x};
    c1_nxt.lim  = {in_data.ref_z, in_data.ref_y, in_data.ref_x};
    c1_nxt.last = in_data.last_vertex;
    c1_nxt.in_sphere = 1'b1;
    s = c1_nxt.src;
    for (int i = 0; i < 3; i++) begin
      d = $signed({s[i][CW-1], s[i]}) - $signed({cfg.cen[i][CW-1], cfg.cen[i]});
      c1_nxt.neg[i] = d[CW];
      a = d[CW] ? (CW+1)'(-d) : d;
      c1_nxt.mag[i] = a[LW-1:0];
      if (a > {2'b00, cfg.rad}) begin
        c1_nxt.in_sphere = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = TW'(c1_r.mag[i] * c1_r.mag[i]);
    end
  end

  always_comb begin
    logic [TW+1:0] sum;
    sum = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
    o_nxt.ctx           = c2_r;
    o_nxt.ctx.in_sphere = c2_r.in_sphere && (sum <= {2'b00, cfg.rsq});
    o_nxt.rad           = o_nxt.ctx.in_sphere ? sum[TW-1:0] : '0;
    o_nxt.rem           = '0;
    o_nxt.root          = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) c1_r <= c1_nxt;
    if (rdy[1] && v_r[0]) begin
      c2_r <= c1_r;
      sq_r <= sq_nxt;
    end
    if (rdy[2] && v_r[1]) o_r <= o_nxt;
  end

endmodule

FILE: rtl/sdvd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sdvd_sqrt_cell
// One root bit of the squared distance per cell.
// ----------------------------------------------------------------------------
module sdvd_sqrt_cell import sdvd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sq_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output sq_t  out_data
);

  logic valid_r;
  sq_t  data_r, data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic [LW+2:0] cur;
    logic [LW+2:0] trial;
    cur   = {in_data.rem, in_data.rad[TW-1:TW-2]};
    trial = {1'b0, in_data.root, 2'b01};
    data_nxt     = in_data;
    data_nxt.rad = {in_data.rad[TW-3:0], 2'b00};
    if (cur >= trial) begin
      data_nxt.rem  = (LW+1)'(cur - trial);
      data_nxt.root = {in_data.root[LW-2:0], 1'b1};
    end else begin
      data_nxt.rem  = cur[LW:0];
      data_nxt.root = {in_data.root[LW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

endmodule

FILE: rtl/sdvd_prod.sv
// ----------------------------------------------------------------------------
// sdvd_prod
// Scales each offset by the radius and adds half the length for rounding.
// ----------------------------------------------------------------------------
module sdvd_prod import sdvd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  sq_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output dv_t  out_data
);

  logic valid_r;
  dv_t  data_r, data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic [NW-1:0] num;
    data_nxt.ctx = in_data.ctx;
    data_nxt.len = in_data.root;
    data_nxt.quo = '0;
    for (int i = 0; i < 3; i++) begin
      num = NW'(in_data.ctx.mag[i] * cfg.rad) + NW'(in_data.root >> 1);
      data_nxt.rem[i]  = num[NW-1:QW];
      data_nxt.feed[i] = num[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

endmodule

FILE: rtl/sdvd_div_cell.sv
// ----------------------------------------------------------------------------
// sdvd_div_cell
// One restoring quotient bit for all three axes per cell.
// ----------------------------------------------------------------------------
module sdvd_div_cell import sdvd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  dv_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output dv_t  out_data
);

  logic valid_r;
  dv_t  data_r, data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic [LW:0] cur;
    logic        ge;
    data_nxt = in_data;
    for (int i = 0; i < 3; i++) begin
      cur = {in_data.rem[i], in_data.feed[i][QW-1]};
      ge  = cur >= {1'b0, in_data.len};
      data_nxt.rem[i]  = ge ? LW'(cur - {1'b0, in_data.len}) : cur[LW-1:0];
      data_nxt.quo[i]  = {in_data.quo[i][QW-2:0], ge};
      data_nxt.feed[i] = {in_data.feed[i][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

endmodule

FILE: rtl/sdvd_back.sv
// ----------------------------------------------------------------------------
// sdvd_back
// Offsets, saturates and clamps inside vertices by the reference, passes others, holds the result.
// ----------------------------------------------------------------------------
module sdvd_back import sdvd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  dv_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic valid_r;
  out_t data_r, data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic signed [CW+1:0] v;
    logic signed [CW+1:0] cx;
    logic signed [CW+1:0] off;
    logic [CW-1:0]        pv;
    logic [2:0][CW-1:0]   p;
    for (int i = 0; i < 3; i++) begin
      cx  = $signed({{2{cfg.cen[i][CW-1]}}, cfg.cen[i]});
      off = $signed({2'b00, in_data.quo[i]});
      if (in_data.len == '0) begin
        v = cx;
      end else if (in_data.ctx.neg[i]) begin
        v = cx - off;
      end else begin
        v = cx + off;
      end
      // Saturate when the top three bits disagree.
      if (v[CW+1:CW-1] == 3'b000 || v[CW+1:CW-1] == 3'b111) begin
        pv = v[CW-1:0];
      end else begin
        pv = {v[CW+1], {(CW-1){!v[CW+1]}}};
      end
      if (!in_data.ctx.in_sphere) begin
        p[i] = in_data.ctx.src[i];
      end else if ($signed(in_data.ctx.lim[i]) < $signed(pv)) begin
        p[i] = in_data.ctx.lim[i];
      end else begin
        p[i] = pv;
      end
    end
    data_nxt.out_x       = p[0];
    data_nxt.out_y       = p[1];
    data_nxt.out_z       = p[2];
    data_nxt.was_inside  = in_data.ctx.in_sphere;
    data_nxt.last_result = in_data.ctx.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

endmodule

FILE: rtl/sphere_dent_vertex_deform_top.sv
// ----------------------------------------------------------------------------
// sphere_dent_vertex_deform_top
// Path from input transaction to result: 3 front stages,
// 15 root cells, one scaling stage, 16 quotient cells, one output stage.
// Throughput: one transaction per cycle unless out_ready stalls; every stage is an elastic register.
// Reset clears all valid flags and the configuration registers to zero.
// ----------------------------------------------------------------------------
module sphere_dent_vertex_deform_top import sdvd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [2:0][CW-1:0] cen_r;
  logic [LW-1:0]      rad_r;
  logic [TW-1:0]      rsq_r;
  cfg_t               cfg;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign cfg    = '{cen: cen_r, rad: rad_r, rsq: rsq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r <= '0;
      rad_r <= '0;
      rsq_r <= '0;
    end else begin
      rsq_r <= TW'(rad_r * rad_r);
      if (psel && penable && pwrite) begin
        unique case (idx)
          REG_CENTER_X: cen_r[0] <= pwdata[CW-1:0];
          REG_CENTER_Y: cen_r[1] <= pwdata[CW-1:0];
          REG_CENTER_Z: cen_r[2] <= pwdata[CW-1:0];
          REG_RADIUS:   rad_r    <= pwdata[LW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_X: prdata = DATA_W'(cen_r[0]);
      REG_CENTER_Y: prdata = DATA_W'(cen_r[1]);
      REG_CENTER_Z: prdata = DATA_W'(cen_r[2]);
      REG_RADIUS:   prdata = DATA_W'(rad_r);
      default:      prdata = '0;
    endcase
  end

  logic [SQRT_CELLS:0] sq_v, sq_rdy;
  sq_t                 sq_d [SQRT_CELLS+1];
  logic [DIV_CELLS:0]  dv_v, dv_rdy;
  dv_t                 dv_d [DIV_CELLS+1];

  sdvd_front u_front (
    .clk, .rst_n, .cfg,
    .in_valid, .in_ready, .in_data,
    .out_valid(sq_v[0]), .out_ready(sq_rdy[0]), .out_data(sq_d[0])
  );

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    sdvd_sqrt_cell u_cell (
      .clk, .rst_n,
      .in_valid(sq_v[k]), .in_ready(sq_rdy[k]), .in_data(sq_d[k]),
      .out_valid(sq_v[k+1]), .out_ready(sq_rdy[k+1]), .out_data(sq_d[k+1])
    );
  end

  sdvd_prod u_prod (
    .clk, .rst_n, .cfg,
    .in_valid(sq_v[SQRT_CELLS]), .in_ready(sq_rdy[SQRT_CELLS]),
    .in_data(sq_d[SQRT_CELLS]),
    .out_valid(dv_v[0]), .out_ready(dv_rdy[0]), .out_data(dv_d[0])
  );

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    sdvd_div_cell u_cell (
      .clk, .rst_n,
      .in_valid(dv_v[k]), .in_ready(dv_rdy[k]), .in_data(dv_d[k]),
      .out_valid(dv_v[k+1]), .out_ready(dv_rdy[k+1]), .out_data(dv_d[k+1])
    );
  end

  sdvd_back u_back (
    .clk, .rst_n, .cfg,
    .in_valid(dv_v[DIV_CELLS]), .in_ready(dv_rdy[DIV_CELLS]),
    .in_data(dv_d[DIV_CELLS]),
    .out_valid, .out_ready, .out_data
  );

endmodule

FILE: bench/sphere_dent_vertex_deform_top_tb.sv
// ----------------------------------------------------------------------------
// Sphere dent vertex deformer testbench
// Drives vertices through the valid/ready input channel and checks every
// deformed vertex against an independent predictor. The sphere is set up over
// the APB port between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module sphere_dent_vertex_deform_top_tb import sdvd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COORD_MAX = 32767;
  localparam longint COORD_MIN = -32768;
  localparam int     LATENCY   = 36;
  localparam longint CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sphere_dent_vertex_deform_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Shadow copy of the sphere registers.
  logic signed [CW-1:0] cen_x = '0, cen_y = '0, cen_z = '0;
  logic [LW-1:0]        radius = '0;

  out_t   deformed_q[$];
  int     error_count = 0;
  longint cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_off_cycles = 0;

  function automatic out_t deform_vertex(in_t v);
    longint c[3], s[3], f[3], d[3], p[3];
    longint unsigned ad[3], r, t, len, off, rem, res, bitv;
    longint vv;
    bit hit;
    out_t o;
    c[0] = cen_x; c[1] = cen_y; c[2] = cen_z;
    s[0] = $signed(v.src_x); s[1] = $signed(v.src_y); s[2] = $signed(v.src_z);
    f[0] = $signed(v.ref_x); f[1] = $signed(v.ref_y); f[2] = $signed(v.ref_z);
    r = radius;
    hit = 1'b1;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = s[i] - c[i];
      ad[i] = d[i] < 0 ? -d[i] : d[i];
      if (ad[i] > r) hit = 1'b0;
    end
    if (hit) begin
      for (int i = 0; i < 3; i++) t += ad[i] * ad[i];
      if (t > r * r) hit = 1'b0;
    end
    if (hit) begin
      // Bitwise integer square root.
      rem = t; res = 0; bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      len = res;
      for (int i = 0; i < 3; i++) begin
        vv = c[i];
        if (len != 0) begin
          off = (ad[i] * r + len / 2) / len;
          vv = d[i] < 0 ? c[i] - longint'(off) : c[i] + longint'(off);
        end
        if (vv > COORD_MAX) vv = COORD_MAX;
        if (vv < COORD_MIN) vv = COORD_MIN;
        p[i] = f[i] < vv ? f[i] : vv;
      end
    end else begin
      for (int i = 0; i < 3; i++) p[i] = s[i];
    end
    o.out_x = p[0][CW-1:0];
    o.out_y = p[1][CW-1:0];
    o.out_z = p[2][CW-1:0];
    o.was_inside = hit;
    o.last_result = v.last_vertex;
    return o;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_t exp_o;
    if (rst_n && out_valid && out_ready) begin
      if (deformed_q.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        error_count++;
      end else begin
        exp_o = deformed_q.pop_front();
        if (out_data.out_x !== exp_o.out_x) begin
          $error("out_x expected %h actual %h", exp_o.out_x, out_data.out_x);
          error_count++;
        end
        if (out_data.out_y !== exp_o.out_y) begin
          $error("out_y expected %h actual %h", exp_o.out_y, out_data.out_y);
          error_count++;
        end
        if (out_data.out_z !== exp_o.out_z) begin
          $error("out_z expected %h actual %h", exp_o.out_z, out_data.out_z);
          error_count++;
        end
        if (out_data.was_inside !== exp_o.was_inside) begin
          $error("was_inside expected %b actual %b", exp_o.was_inside,
                 out_data.was_inside);
          error_count++;
        end
        if (out_data.last_result !== exp_o.last_result) begin
          $error("last_result expected %b actual %b", exp_o.last_result,
                 out_data.last_result);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X: cen_x = value[CW-1:0];
      REG_CENTER_Y: cen_y = value[CW-1:0];
      REG_CENTER_Z: cen_z = value[CW-1:0];
      REG_RADIUS:   radius = value[LW-1:0];
    endcase
  endtask

  // Upper bits of the centre X and radius writes carry random junk, which the block must ignore.
  task automatic set_sphere(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                            logic [LW-1:0] r);
    write_reg(REG_CENTER_X, {16'($urandom), x});
    write_reg(REG_CENTER_Y, {16'h0, y});
    write_reg(REG_CENTER_Z, {16'h0, z});
    write_reg(REG_RADIUS, {17'($urandom), r});
  endtask

  // Valid stays high into the next call so that transactions can follow
  // back to back; it is dropped while idling and in drain().
  task automatic send_vertex(in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (!in_ready);
    deformed_q.push_back(deform_vertex(v));
    @(negedge clk);
  endtask

  // The block has no results without items, so draining the queue is enough.
  task automatic drain();
    in_valid <= 1'b0;
    while (deformed_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CW-1:0] near(logic [CW-1:0] c, int spread);
    longint v;
    v = longint'($signed(c)) + $urandom_range(2 * spread) - spread;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[CW-1:0];
  endfunction

  function automatic in_t random_vertex();
    in_t v;
    int spread;
    v = in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom}));
    v.last_vertex = ($urandom_range(15) == 0);
    // Most vertices fall close to the sphere so that the dent path is used.
    if ($urandom_range(9) < 8) begin
      spread = int'(radius) + 2;
      v.src_x = near(cen_x, spread);
      v.src_y = near(cen_y, spread);
      v.src_z = near(cen_z, spread);
      if ($urandom_range(3) == 0) begin
        v.ref_x = near(v.src_x, spread);
        v.ref_y = near(v.src_y, spread);
        v.ref_z = near(v.src_z, spread);
      end else if ($urandom_range(2) == 0) begin
        v.ref_x = 16'h7fff; v.ref_y = 16'h7fff; v.ref_z = 16'h7fff;
      end
    end
    return v;
  endfunction

  task automatic test_directed();
    in_t v;
    send_idle_pct = 0; recv_stall_pct = 0;
    set_sphere(16'h0000, 16'h0000, 16'h0000, 15'd0);
    v = '0; send_vertex(v);                       // zero radius, zero distance
    v = '1; send_vertex(v);
    drain();
    set_sphere(16'h1000, 16'hf000, 16'h0100, 15'h2000);
    v = '0; v.src_x = 16'h1000; v.src_y = 16'hf000; v.src_z = 16'h0100;
    v.ref_x = 16'h7fff; v.ref_y = 16'h7fff; v.ref_z = 16'h7fff;
    send_vertex(v);                               // source on the centre
    v.ref_x = 16'h8000; v.ref_y = 16'h8000; v.ref_z = 16'h8000;
    send_vertex(v);                               // reference clamps all axes
    v.src_x = 16'h3000; send_vertex(v);           // exactly on the surface
    v.src_x = 16'h3001; v.last_vertex = 1; send_vertex(v);  // just outside
    v = '0; v.src_x = 16'h1100; v.src_y = 16'hf100; v.src_z = 16'h00f0;
    v.ref_x = 16'h7fff; v.ref_y = 16'h7fff; v.ref_z = 16'h7fff;
    send_vertex(v);
    v.src_x = 16'h7fff; v.src_y = 16'h8000; send_vertex(v);
    drain();
    set_sphere(16'h7fff, 16'h8000, 16'h7fff, 15'h7fff);  // centre on the coordinate extremes
    v = '0; v.src_x = 16'h7000; v.src_y = 16'h9000; v.src_z = 16'h7ff0;
    v.ref_x = 16'h7fff; v.ref_y = 16'h7fff; v.ref_z = 16'h7fff;
    send_vertex(v);
    v.src_x = 16'h7fff; v.src_y = 16'h8000; v.src_z = 16'h7ffe; send_vertex(v);
    v.src_x = 16'h8000; v.src_y = 16'h7fff; v.src_z = 16'h8000; send_vertex(v);
    drain();
    set_sphere(16'h8000, 16'h7fff, 16'h8000, 15'h0001);
    v.src_x = 16'h8001; v.src_y = 16'h7fff; v.src_z = 16'h8000; send_vertex(v);
    v.src_x = 16'h8001; v.src_y = 16'h7ffe; v.src_z = 16'h8000; send_vertex(v);
    v = '1; send_vertex(v);
    drain();
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct; recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_vertex(random_vertex());
    drain();
  endtask

  task automatic test_random_phases();
    logic [LW-1:0] radii[4];
    radii[0] = 15'h7fff; radii[1] = 15'h0010;
    radii[2] = LW'($urandom); radii[3] = 15'h0400;
    for (int ph = 0; ph < 4; ph++) begin
      set_sphere(CW'($urandom), CW'($urandom), CW'($urandom), radii[ph]);
      run_random(80, 0, 0);
      run_random(80, 71, 0);
      run_random(80, 0, 71);
      run_random(80, 15, 15);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    set_sphere(16'h0000, 16'h0000, 16'h0000, 15'h1000);
    hold_off_cycles = 300;
    for (int i = 0; i < 100; i++) send_vertex(random_vertex());
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phases();
    test_backpressure();
    repeat (LATENCY + 10) @(negedge clk);
    if (error_count == 0 && deformed_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
